// File: rtl/u8sd_pkg.sv
// ----------------------------------------------------------------------------
// u8sd_pkg
// Types, constants and lead byte helpers for the six-byte UTF-8 decoder.
// ----------------------------------------------------------------------------
package u8sd_pkg;

   localparam int unsigned BYTE_W   = 8;
   localparam int unsigned CP_W     = 31;
   localparam int unsigned CNT_W    = 3;
   localparam int unsigned MAX_RES  = 6;
   localparam int unsigned PEND_MAX = 5;

   localparam logic [7:0] ASCII_MAX  = 8'h7F;
   localparam logic [7:0] MASK_LEN2  = 8'hE0;
   localparam logic [7:0] TAG_LEN2   = 8'hC0;
   localparam logic [7:0] MASK_LEN3  = 8'hF0;
   localparam logic [7:0] TAG_LEN3   = 8'hE0;
   localparam logic [7:0] MASK_LEN4  = 8'hF8;
   localparam logic [7:0] TAG_LEN4   = 8'hF0;
   localparam logic [7:0] MASK_LEN5  = 8'hFC;
   localparam logic [7:0] TAG_LEN5   = 8'hF8;
   localparam logic [7:0] MASK_LEN6  = 8'hFE;
   localparam logic [7:0] TAG_LEN6   = 8'hFC;
   localparam logic [7:0] MASK_CONT  = 8'hC0;
   localparam logic [7:0] TAG_CONT   = 8'h80;
   localparam logic [5:0] PAYLOAD6   = 6'h3F;

   localparam logic [2:0] LEN_LATCH  = 3'd5;

   // One queued unit of output work: either one completed codepoint, or a run
   // of raw one-byte results taken from bytes[0..n-1].
   typedef struct packed {
      logic [MAX_RES-1:0][BYTE_W-1:0] bytes;
      logic [CNT_W-1:0]               n;
      logic                           is_cp;
      logic [CP_W-1:0]                cp;
      logic [CNT_W-1:0]               cnt;
   } job_type;

   function automatic logic [2:0] lead_len(input logic [7:0] b);
      logic [2:0] len;
      len = 3'd1;
      if ((b & MASK_LEN2) == TAG_LEN2) begin
         len = 3'd2;
      end else if ((b & MASK_LEN3) == TAG_LEN3) begin
         len = 3'd3;
      end else if ((b & MASK_LEN4) == TAG_LEN4) begin
         len = 3'd4;
      end else if ((b & MASK_LEN5) == TAG_LEN5) begin
         len = 3'd5;
      end else if ((b & MASK_LEN6) == TAG_LEN6) begin
         len = 3'd6;
      end
      return len;
   endfunction

   // Payload bits of a lead byte: ASCII_MAX >> len.
   function automatic logic [7:0] lead_bits(input logic [7:0] b, input logic [2:0] len);
      return b & (ASCII_MAX >> len);
   endfunction

endpackage

// File: rtl/u8sd_if.sv
// ----------------------------------------------------------------------------
// u8sd channel interfaces
// Valid/ready channels for the byte input and the codepoint output.
// ----------------------------------------------------------------------------
interface u8sd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] byte_req;
   logic       end_of_text;

   modport source (output valid, output byte_req, output end_of_text, input ready);
   modport sink   (input valid, input byte_req, input end_of_text, output ready);
endinterface

interface u8sd_rsp_if;
   logic        valid;
   logic        ready;
   logic [30:0] codepoint;
   logic [2:0]  span;
   logic        last_of_run;

   modport source (output valid, output codepoint, output span,
                   output last_of_run, input ready);
   modport sink   (input valid, input codepoint, input span,
                   input last_of_run, output ready);
endinterface

// File: rtl/u8sd_front.sv
// ----------------------------------------------------------------------------
// u8sd_front
// Accepts bytes, tracks the pending sequence and builds output jobs.
// ----------------------------------------------------------------------------
module u8sd_front (
   input  logic                 clock,
   input  logic                 reset,
   u8sd_req_if.sink             req,
   input  logic                 csr_write_en,
   input  logic                 csr_write_data,
   input  logic                 q_ready,
   output logic                 q_push,
   output u8sd_pkg::job_type    q_job
);

   logic [2:0]  pc_ff, pc_in;
   logic [2:0]  el_ff, el_in;
   logic [30:0] part_ff, part_in;
   logic        latched_ff, latched_in;
   logic        check_ff;
   logic [7:0]  pb_ff [u8sd_pkg::PEND_MAX];

   logic        accept;
   logic [7:0]  b;
   logic        eot;
   logic        chk;
   logic [2:0]  len;
   logic        start;
   logic        is_cont;
   logic        fresh;
   logic [2:0]  pc_inc;
   logic        complete;
   logic        append_b;
   logic [2:0]  keep_n;
   logic [2:0]  n;
   logic [30:0] part_ext;
   logic        wr_first;
   logic        wr_ext;

   assign accept   = req.valid && req.ready;
   assign req.ready = q_ready;
   assign b        = req.byte_req;
   assign eot      = req.end_of_text;
   assign chk      = check_ff | latched_ff;
   assign len      = u8sd_pkg::lead_len(b);
   assign start    = (len >= 3'd2);
   assign is_cont  = ((b & u8sd_pkg::MASK_CONT) == u8sd_pkg::TAG_CONT);
   assign fresh    = (pc_ff == 3'd0) || (chk && !is_cont);
   assign pc_inc   = pc_ff + 3'd1;
   assign complete = !fresh && (pc_inc >= el_ff);
   assign part_ext = {part_ff[24:0], b[5:0] & u8sd_pkg::PAYLOAD6};

   // held bytes go out first, then the current byte when it ends up raw
   assign append_b = fresh ? (!start || eot) : (!complete && eot);
   assign keep_n   = (fresh || (eot && !complete)) ? pc_ff : 3'd0;
   assign n        = complete ? 3'd1 : (keep_n + {2'b00, append_b});

   always_comb begin
      q_job.n     = n;
      q_job.is_cp = complete;
      q_job.cp    = part_ext;
      q_job.cnt   = el_ff;
      for (int i = 0; i < int'(u8sd_pkg::PEND_MAX); i++) begin
         q_job.bytes[i] = (3'(i) < pc_ff) ? pb_ff[i] : b;
      end
      q_job.bytes[u8sd_pkg::MAX_RES-1] = b;
   end

   assign q_push = accept && (complete || (n != 3'd0));

   assign wr_first = accept && fresh && start && !eot;
   assign wr_ext   = accept && !fresh && !complete && !eot;

   always_comb begin
      pc_in      = pc_ff;
      el_in      = el_ff;
      part_in    = part_ff;
      latched_in = latched_ff;
      if (accept) begin
         if (fresh) begin
            if (start && (len == u8sd_pkg::LEN_LATCH)) begin
               latched_in = 1'b1;
            end
            if (start && !eot) begin
               pc_in   = 3'd1;
               el_in   = len;
               part_in = {23'd0, u8sd_pkg::lead_bits(b, len)};
            end else begin
               pc_in   = 3'd0;
               el_in   = 3'd0;
               part_in = '0;
            end
         end else if (complete || eot) begin
            pc_in   = 3'd0;
            el_in   = 3'd0;
            part_in = '0;
         end else begin
            pc_in   = pc_inc;
            part_in = part_ext;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff      <= 3'd0;
         el_ff      <= 3'd0;
         part_ff    <= '0;
         latched_ff <= 1'b0;
         check_ff   <= 1'b0;
      end else begin
         pc_ff      <= pc_in;
         el_ff      <= el_in;
         part_ff    <= part_in;
         latched_ff <= latched_in;
         if (csr_write_en) begin
            check_ff <= csr_write_data;
         end
      end
   end

   for (genvar g = 0; g < int'(u8sd_pkg::PEND_MAX); g++) begin : g_pend
      always_ff @(posedge clock) begin
         if ((wr_first && (g == 0)) || (wr_ext && (pc_ff == 3'(g)))) begin
            pb_ff[g] <= b;
         end
      end
   end

endmodule

// File: rtl/u8sd_queue.sv
// ----------------------------------------------------------------------------
// u8sd_queue
// Small job FIFO between the front and back ends.
// ----------------------------------------------------------------------------
module u8sd_queue #(
   parameter int unsigned DEPTH = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  u8sd_pkg::job_type push_job,
   output logic              in_ready,
   input  logic              pop,
   output logic              out_valid,
   output u8sd_pkg::job_type head_job
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   u8sd_pkg::job_type  job_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ff, wr_in;
   logic [PTR_W-1:0]   rd_ff, rd_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               do_push;
   logic               do_pop;

   assign in_ready  = (cnt_ff != CNT_W'(DEPTH));
   assign out_valid = (cnt_ff != '0);
   assign head_job  = job_ff[rd_ff];
   assign do_push   = push && in_ready;
   assign do_pop    = pop && out_valid;

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (do_push) begin
         wr_in = (wr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_in = (rd_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         job_ff[wr_ff] <= push_job;
      end
   end

endmodule

// File: rtl/u8sd_back.sv
// ----------------------------------------------------------------------------
// u8sd_back
// Walks the head job into the output register, one result per cycle unless rsp is stalled.
// ----------------------------------------------------------------------------
module u8sd_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_valid,
   input  u8sd_pkg::job_type q_job,
   output logic              q_pop,
   u8sd_rsp_if.source        rsp
);

   logic [2:0]  idx_ff, idx_in;
   logic        valid_ff;
   logic [30:0] cp_ff, cp_in;
   logic [2:0]  cnt_ff, cnt_in;
   logic        last_ff, last_in;
   logic        load;
   logic        take;
   logic        last_entry;

   assign load       = !valid_ff || rsp.ready;
   assign take       = load && q_valid;
   assign last_entry = q_job.is_cp || (idx_ff == (q_job.n - 3'd1));
   assign q_pop      = take && last_entry;

   always_comb begin
      idx_in = idx_ff;
      if (q_pop) begin
         idx_in = 3'd0;
      end else if (take) begin
         idx_in = idx_ff + 3'd1;
      end
      if (q_job.is_cp) begin
         cp_in  = q_job.cp;
         cnt_in = q_job.cnt;
      end else begin
         cp_in  = {23'd0, q_job.bytes[idx_ff]};
         cnt_in = 3'd1;
      end
      last_in = last_entry;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= 3'd0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff <= idx_in;
         if (load) begin
            valid_ff <= q_valid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         cp_ff   <= cp_in;
         cnt_ff  <= cnt_in;
         last_ff <= last_in;
      end
   end

   assign rsp.valid       = valid_ff;
   assign rsp.codepoint   = cp_ff;
   assign rsp.span        = cnt_ff;
   assign rsp.last_of_run = last_ff;

endmodule

// File: rtl/utf8_stream_decoder_top.sv
// ----------------------------------------------------------------------------
// utf8_stream_decoder_top
// Streaming decoder for six-byte UTF-8, one byte in per cycle while the job queue has room.
//
//   channel  | dir | payload                               | handshake
//   req_ch   | in  | byte_req[7:0], end_of_text            | valid/ready
//   rsp_ch   | out | codepoint[30:0], span[2:0], last      | valid/ready
//   csr_*    | in  | csr_write_data (check_continuations)  | write enable
//
// Bytes are accepted every cycle while the job queue has room; the front end
// updates the sequence state in the accept cycle. Each beat yields 0 to 6
// results, drained by the back end at one per cycle while rsp_ch is not
// stalled, and later bytes keep queueing meanwhile. A byte's first result is
// registered in the job queue and then in the output register. Reset is
// synchronous and clears the sequence state, the queue and the output register.
// ----------------------------------------------------------------------------
module utf8_stream_decoder_top #(
   parameter int unsigned QUEUE_DEPTH = 4
) (
   input  logic        clock,
   input  logic        reset,
   u8sd_req_if.sink    req_ch,
   u8sd_rsp_if.source  rsp_ch,
   input  logic        csr_write_en,
   input  logic        csr_write_data
);

   logic              q_push;
   logic              q_ready;
   logic              q_pop;
   logic              q_valid;
   u8sd_pkg::job_type push_job;
   u8sd_pkg::job_type head_job;

   u8sd_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req            (req_ch),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .q_ready        (q_ready),
      .q_push         (q_push),
      .q_job          (push_job)
   );

   u8sd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_job  (push_job),
      .in_ready  (q_ready),
      .pop       (q_pop),
      .out_valid (q_valid),
      .head_job  (head_job)
   );

   u8sd_back u_back (
      .clock   (clock),
      .reset   (reset),
      .q_valid (q_valid),
      .q_job   (head_job),
      .q_pop   (q_pop),
      .rsp     (rsp_ch)
   );

endmodule

// File: rtl/u8sd_checker.sv
// ----------------------------------------------------------------------------
// u8sd_checker
// Port-level checks on the decoder output, bound to the top level.
// ----------------------------------------------------------------------------
module u8sd_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [30:0] rsp_codepoint,
   input logic [2:0]  rsp_span,
   input logic        rsp_last_of_run
);

   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp beat dropped while stalled");

   a_count_range : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_span != 3'd0) && (rsp_span != 3'd7))
      else $error("span out of range");

   a_multi_alone : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_span != 3'd1) |-> rsp_last_of_run)
      else $error("multi-byte codepoint not last of run");

   a_raw_narrow : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_span == 3'd1) |-> (rsp_codepoint[30:8] == '0))
      else $error("one-byte result wider than a byte");

   a_reset_idle : assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("rsp valid right after reset");

endmodule

bind utf8_stream_decoder_top u8sd_checker u_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_ch.valid),
   .rsp_ready       (rsp_ch.ready),
   .rsp_codepoint   (rsp_ch.codepoint),
   .rsp_span        (rsp_ch.span),
   .rsp_last_of_run (rsp_ch.last_of_run)
);
